[sv/lpht_pkg.sv]
`default_nettype none

package lpht_pkg;

  localparam int KEY_W    = 32;
  localparam int STATUS_W = 2;
  localparam int SLOT_W   = 7;

  typedef logic [KEY_W-1:0]    key_t;
  typedef logic [STATUS_W-1:0] status_t;
  typedef logic [SLOT_W-1:0]   slot_t;

  // request codes
  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_SEARCH = 1'b1;

  // result codes
  localparam status_t ST_INSERTED  = 2'd0;
  localparam status_t ST_FULL      = 2'd1;
  localparam status_t ST_FOUND     = 2'd2;
  localparam status_t ST_NOT_FOUND = 2'd3;

  // controller -> datapath
  typedef struct packed {
    logic clr_step;   // clear one slot during the post-reset pass
    logic load_req;   // capture an accepted request
    logic mod_step;   // one stage of key mod SLOTS
    logic scan_seed;  // start the probe at the home slot
    logic scan_step;  // issue one read / check one slot
    logic load_out;   // move the result into the output register
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic clr_done;
    logic mod_done;
    logic scan_end;   // hit or every slot checked
    logic out_busy;   // output register still holds an untaken beat
  } dp_sts_t;

endpackage

`default_nettype wire

[sv/lpht_if.sv]
`default_nettype none

interface lpht_in_if;
  import lpht_pkg::*;

  logic valid;
  logic ready;
  logic req_type;
  key_t key;

  modport source (output valid, output req_type, output key, input ready);
  modport sink   (input valid, input req_type, input key, output ready);
endinterface

interface lpht_out_if;
  import lpht_pkg::*;

  logic    valid;
  logic    ready;
  status_t status;
  slot_t   slot;

  modport source (output valid, output status, output slot, input ready);
  modport sink   (input valid, input status, input slot, output ready);
endinterface

`default_nettype wire

[sv/lpht_ctrl.sv]
`default_nettype none

module lpht_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  input  wire logic              in_req_type,
  output logic                   in_ready,
  input  wire lpht_pkg::dp_sts_t sts,
  output lpht_pkg::dp_cmd_t      cmd
);
  import lpht_pkg::*;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_MOD   = 3'd2;
  localparam logic [2:0] S_SEED  = 3'd3;
  localparam logic [2:0] S_SCAN  = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  logic [2:0] state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_done) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_req = 1'b1;
          state_nxt    = (in_req_type == REQ_SEARCH) ? S_SCAN : S_MOD;
        end
      end
      S_MOD: begin
        cmd.mod_step = 1'b1;
        if (sts.mod_done) state_nxt = S_SEED;
      end
      S_SEED: begin
        cmd.scan_seed = 1'b1;
        state_nxt     = S_SCAN;
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_end) state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!sts.out_busy) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

endmodule

`default_nettype wire

[sv/lpht_dp.sv]
`default_nettype none

module lpht_dp #(
  parameter int SLOTS = 128
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire lpht_pkg::dp_cmd_t cmd,
  output lpht_pkg::dp_sts_t      sts,
  input  wire logic              in_req_type,
  input  wire lpht_pkg::key_t    in_key,
  input  wire logic              out_ready,
  output logic                   out_valid,
  output lpht_pkg::status_t      out_status,
  output lpht_pkg::slot_t        out_slot
);
  import lpht_pkg::*;

  localparam int IDX_W = $clog2(SLOTS);
  localparam int CNT_W = IDX_W + 1;

  localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(SLOTS - 1);
  localparam logic [CNT_W-1:0] SLOTS_CNT = CNT_W'(SLOTS);
  // floor(2^32 / SLOTS): quotient estimate is exact or one short
  localparam logic [KEY_W-1:0] RECIP     = KEY_W'((64'd1 << KEY_W) / SLOTS);

  // remainder stages
  localparam logic [1:0] MOD_MUL  = 2'd0;
  localparam logic [1:0] MOD_SUB  = 2'd1;
  localparam logic [1:0] MOD_LAST = 2'd2;

  // slot memory: {occupied, key}
  logic [KEY_W:0] mem [SLOTS];

  logic               req_ins_r;
  key_t               key_r;
  logic [2*KEY_W-1:0] prod_r;
  logic [CNT_W-1:0]   rest_r;
  logic [1:0]         mod_cnt_r;
  logic [IDX_W-1:0]   rem_r;
  logic [IDX_W-1:0]   addr_r;
  logic [CNT_W-1:0]   cnt_r;
  logic               chk_v_r;
  logic [IDX_W-1:0]   chk_addr_r;
  logic [KEY_W:0]     rd_data_r;
  status_t            res_status_r;
  slot_t              res_slot_r;
  logic               out_valid_r;
  status_t            out_status_r;
  slot_t              out_slot_r;

  logic [CNT_W-1:0] rest_red;
  logic [IDX_W-1:0] addr_inc;
  logic             issued_all;
  logic             rd_en;
  logic             hit;
  logic             exhausted;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  logic [KEY_W:0]   wr_data;
  logic [IDX_W+SLOT_W-1:0] slot_ext;

  // key - q_est * SLOTS lies in [0, 2*SLOTS): one compare-subtract
  assign rest_red = (rest_r >= SLOTS_CNT) ? rest_r - SLOTS_CNT : rest_r;

  assign addr_inc   = (addr_r == LAST_IDX) ? '0 : addr_r + 1'b1;
  assign issued_all = (cnt_r == SLOTS_CNT);
  assign rd_en      = cmd.scan_step && !issued_all;
  assign hit        = chk_v_r && (req_ins_r ? !rd_data_r[KEY_W]
                                            : (rd_data_r[KEY_W] &&
                                               rd_data_r[KEY_W-1:0] == key_r));
  assign exhausted  = !chk_v_r && issued_all;

  assign wr_en   = cmd.clr_step || (cmd.scan_step && hit && req_ins_r);
  assign wr_addr = cmd.clr_step ? addr_r : chk_addr_r;
  assign wr_data = cmd.clr_step ? '0 : {1'b1, key_r};

  assign slot_ext = {{SLOT_W{1'b0}}, chk_addr_r};

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_data_r <= mem[addr_r];
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      addr_r      <= '0;
      cnt_r       <= '0;
      chk_v_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.clr_step) begin
        addr_r <= addr_inc;
      end else if (cmd.load_req) begin
        addr_r <= '0;
        cnt_r  <= '0;
      end else if (cmd.scan_seed) begin
        addr_r <= rem_r;
        cnt_r  <= '0;
      end else if (rd_en) begin
        addr_r <= addr_inc;
        cnt_r  <= cnt_r + 1'b1;
      end
      chk_v_r <= rd_en;
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      req_ins_r <= (in_req_type == REQ_INSERT);
      key_r     <= in_key;
      mod_cnt_r <= MOD_MUL;
    end else if (cmd.mod_step) begin
      mod_cnt_r <= mod_cnt_r + 1'b1;
      case (mod_cnt_r)
        MOD_MUL: begin
          prod_r <= (2*KEY_W)'(key_r) * (2*KEY_W)'(RECIP);
        end
        MOD_SUB: begin
          // only the low bits matter, the true difference is small
          rest_r <= key_r[CNT_W-1:0] - prod_r[KEY_W +: CNT_W] * SLOTS_CNT;
        end
        default: begin
          rem_r <= rest_red[IDX_W-1:0];
        end
      endcase
    end
    if (rd_en) chk_addr_r <= addr_r;
    if (cmd.scan_step && hit) begin
      res_status_r <= req_ins_r ? ST_INSERTED : ST_FOUND;
      res_slot_r   <= slot_ext[SLOT_W-1:0];
    end else if (cmd.scan_step && exhausted) begin
      res_status_r <= req_ins_r ? ST_FULL : ST_NOT_FOUND;
      res_slot_r   <= '0;
    end
    if (cmd.load_out) begin
      out_status_r <= res_status_r;
      out_slot_r   <= res_slot_r;
    end
  end

  assign sts.clr_done = (addr_r == LAST_IDX);
  assign sts.mod_done = (mod_cnt_r == MOD_LAST);
  assign sts.scan_end = hit || exhausted;
  assign sts.out_busy = out_valid_r && !out_ready;

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_slot   = out_slot_r;

endmodule

`default_nettype wire

[sv/linear_probe_hash_table.sv]
// Linear-probing hash table of SLOTS 32-bit keys.
// in_chan (sink): one beat per request, req_type 0 = insert, 1 = search.
// out_chan (source): one beat per request, status + slot.
//   status: inserted / table full / found / not found; slot is 0 on a miss.
// Insert: key mod SLOTS is worked out by reciprocal multiply and reduce,
//   then slots are probed upward from there, wrapping, one per cycle.
// Search: slots are scanned from slot 0 upward, one per cycle.
// The slot memory has one read port, so slots are read one per cycle.
// One request is in flight at a time; the next beat is taken once the
//   current result sits in the output register.
// Reset (rst_n low, synchronous) starts a clearing pass that empties
//   every slot; in_chan.ready stays low throughout.
// A stalled receiver holds the result in the output register; a finished
//   second request waits until that beat is taken.
`default_nettype none

module linear_probe_hash_table #(
  parameter int SLOTS = 128
) (
  input wire logic  clk,
  input wire logic  rst_n,
  lpht_in_if.sink   in_chan,
  lpht_out_if.source out_chan
);
  import lpht_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  // sequencer: clear pass, modulo, probe, result handoff
  lpht_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_chan.valid),
    .in_req_type(in_chan.req_type),
    .in_ready   (in_chan.ready),
    .sts        (sts),
    .cmd        (cmd)
  );

  // slot memory, remainder unit, probe pipe and output register
  lpht_dp #(
    .SLOTS(SLOTS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_req_type(in_chan.req_type),
    .in_key     (in_chan.key),
    .out_ready  (out_chan.ready),
    .out_valid  (out_chan.valid),
    .out_status (out_chan.status),
    .out_slot   (out_chan.slot)
  );

endmodule

`default_nettype wire

[sv/lpht_checker.sv]
`default_nettype none

module lpht_checker (
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              in_valid,
  input wire logic              in_ready,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire lpht_pkg::status_t out_status,
  input wire lpht_pkg::slot_t   out_slot
);
  import lpht_pkg::*;

  // reset starts the clearing pass: no request taken right after
  a_clear_after_reset: assert property (@(posedge clk)
    !rst_n |=> !in_ready)
    else $error("request channel ready right after reset");

  // one request in flight: ready drops after an accepted beat
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second request taken while one is in flight");

  // misses carry slot zero
  a_miss_slot_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_FULL || out_status == ST_NOT_FOUND)
      |-> out_slot == '0)
    else $error("miss result with nonzero slot");

  // a result beat stays until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) && $stable(out_slot))
    else $error("result beat dropped or changed while stalled");

endmodule

bind linear_probe_hash_table lpht_checker u_lpht_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_chan.valid),
  .in_ready  (in_chan.ready),
  .out_valid (out_chan.valid),
  .out_ready (out_chan.ready),
  .out_status(out_chan.status),
  .out_slot  (out_chan.slot)
);

`default_nettype wire
